[rtl/core/lfks_pkg.sv]
// Shared word types and codes for the LED fade keyframe sequencer.
package lfks_pkg;

    localparam logic [1:0] CMD_STEP   = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_LEVEL = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic        restart;
        logic [7:0]  start_level;
        logic [7:0]  end_level;
        logic [31:0] fade_ms;
        logic [31:0] delay_ms;
        logic        go_back;
    } t_in_word;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] level;
        logic [3:0] entry_index;
        logic       last;
    } t_out_word;

endpackage

[rtl/core/lfks_div.sv]
// Bit-serial restoring divider for the fade interpolation, one quotient bit per cycle.
module lfks_div #(
    parameter int QW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [QW+31:0]   i_dividend,
    input  logic [31:0]      i_divisor,
    output logic             o_done,
    output logic [QW-1:0]    o_quot
);

    localparam int CNTW = $clog2(QW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [31:0]     r_rem;
    logic [QW-1:0]   r_q;
    logic [31:0]     r_dvs;

    logic [32:0]     w_trial;
    logic            w_ge;
    logic [32:0]     w_diff;
    logic [QW:0]     w_qsh;

    always_comb begin
        w_trial = {r_rem, r_q[QW-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
        w_qsh   = {r_q, w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[QW+31:QW];
            r_q   <= i_dividend[QW-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_q   <= w_qsh[QW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[rtl/core/led_fade_keyframe_sequencer_unit.sv]
// Top level of the LED fade keyframe sequencer: entry table, sequencer and output stage.
// An append word goes from decode to send; a clear, an idle step or an unused code returns to idle.
// A step passes decode, read and evaluate; a waiting step then returns to idle, and a start or
// end level step sends its word(s); an interpolated step passes multiply, divide start and divide.
// Throughput: one word at a time; the next is taken the cycle after its last result is accepted.
// Synchronous active-low reset clears the sequencer and entry count; table contents stay undefined.
module led_fade_keyframe_sequencer_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int LEVEL_BITS  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lfks_pkg::t_in_word   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lfks_pkg::t_out_word  o_out_data
);

    import lfks_pkg::*;

    localparam int LW = (LEVEL_BITS < 8) ? LEVEL_BITS : 8;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EVAL = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_DST  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_SEND = 4'd7;

    typedef struct packed {
        logic [LW-1:0] start_lv;
        logic [LW-1:0] end_lv;
        logic [31:0]   fade;
        logic [31:0]   delay;
        logic          back;
    } t_entry;

    t_entry          r_mem [MAX_ENTRIES];
    t_entry          r_ent;
    t_entry          w_wr_entry;
    logic            w_mem_we;

    logic [3:0]      r_state, n_state;
    t_in_word        r_in, n_in;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_active, n_active;
    logic            r_sched, n_sched;
    logic [31:0]     r_due, n_due;
    logic            r_running, n_running;
    logic [31:0]     r_begin, n_begin;
    logic [31:0]     r_elapsed, n_elapsed;
    logic [LW+31:0]  r_prod, n_prod;
    logic            r_neg, n_neg;
    t_out_word       r_out, n_out;
    t_out_word       r_out2, n_out2;
    logic            r_out_valid, n_out_valid;
    logic            r_pend2, n_pend2;

    logic            w_div_start;
    logic            w_div_done;
    logic [LW-1:0]   w_quot;

    logic [CW+3:0]   w_idx_ext;
    logic [CW+3:0]   w_cnt_ext;
    logic [31:0]     w_due_eff;
    logic [31:0]     w_since_due;
    logic [31:0]     w_elapsed;
    logic [LW:0]     w_diff;
    logic [LW:0]     w_absdiff;
    logic [LW:0]     w_lv;
    logic [LW+7:0]   w_start_ext;
    logic [LW+7:0]   w_end_ext;
    logic [LW+7:0]   w_lv_ext;

    lfks_div #(
        .QW (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_ent.fade),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_wr_entry.start_lv = r_in.start_level[LW-1:0];
        w_wr_entry.end_lv   = r_in.end_level[LW-1:0];
        w_wr_entry.fade     = r_in.fade_ms;
        w_wr_entry.delay    = r_in.delay_ms;
        w_wr_entry.back     = r_in.go_back;

        w_idx_ext   = {4'b0, r_active};
        w_cnt_ext   = {4'b0, r_count};
        w_due_eff   = r_sched ? r_due : (r_in.now_ms + r_ent.delay);
        w_since_due = r_in.now_ms - w_due_eff;
        w_elapsed   = r_in.now_ms - r_begin;
        w_diff      = {1'b0, r_ent.end_lv} - {1'b0, r_ent.start_lv};
        w_absdiff   = w_diff[LW] ? (~w_diff + 1'b1) : w_diff;
        w_lv        = r_neg ? ({1'b0, r_ent.start_lv} - {1'b0, w_quot})
                            : ({1'b0, r_ent.start_lv} + {1'b0, w_quot});
        w_start_ext = {8'b0, r_ent.start_lv};
        w_end_ext   = {8'b0, r_ent.end_lv};
        w_lv_ext    = {8'b0, w_lv[LW-1:0]};
    end

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_count     = r_count;
        n_active    = r_active;
        n_sched     = r_sched;
        n_due       = r_due;
        n_running   = r_running;
        n_begin     = r_begin;
        n_elapsed   = r_elapsed;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_out       = r_out;
        n_out2      = r_out2;
        n_out_valid = r_out_valid;
        n_pend2     = r_pend2;
        w_mem_we    = 1'b0;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                case (r_in.cmd)
                    CMD_APPEND: begin
                        n_out.level = '0;
                        n_out.last  = 1'b1;
                        if (r_count < CW'(MAX_ENTRIES)) begin
                            w_mem_we          = 1'b1;
                            n_count           = r_count + 1'b1;
                            n_out.kind        = KIND_ACK;
                            n_out.entry_index = w_cnt_ext[3:0];
                        end else begin
                            n_out.kind        = KIND_FULL;
                            n_out.entry_index = '0;
                        end
                        n_out_valid = 1'b1;
                        n_pend2     = 1'b0;
                        n_state     = S_SEND;
                    end
                    CMD_CLEAR: begin
                        n_active  = '0;
                        n_sched   = 1'b0;
                        n_running = 1'b0;
                        n_due     = '0;
                        n_begin   = '0;
                    end
                    CMD_STEP: begin
                        if (r_in.restart) begin
                            n_active  = '0;
                            n_sched   = 1'b0;
                            n_running = 1'b0;
                            n_due     = '0;
                            n_begin   = '0;
                            if (r_count != '0) begin
                                n_state = S_RD;
                            end
                        end else if (r_active < r_count) begin
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_due   = w_due_eff;
                n_sched = 1'b1;
                n_state = S_IDLE;
                n_out.kind        = KIND_LEVEL;
                n_out.entry_index = w_idx_ext[3:0];
                n_out2.kind        = KIND_LEVEL;
                n_out2.entry_index = w_idx_ext[3:0];
                n_out2.level       = w_end_ext[7:0];
                n_out2.last        = 1'b1;
                if (!w_since_due[31]) begin
                    if (!r_running) begin
                        n_running   = 1'b1;
                        n_begin     = r_in.now_ms;
                        n_out.level = w_start_ext[7:0];
                        n_out.last  = (r_ent.fade != '0);
                        n_out_valid = 1'b1;
                        n_pend2     = (r_ent.fade == '0);
                        n_state     = S_SEND;
                        if (r_ent.fade == '0) begin
                            n_sched   = 1'b0;
                            n_running = 1'b0;
                            n_due     = '0;
                            n_begin   = '0;
                            n_active  = r_ent.back ? '0 : CW'(r_active + 1'b1);
                        end
                    end else if (w_elapsed >= r_ent.fade) begin
                        n_out.level = w_end_ext[7:0];
                        n_out.last  = 1'b1;
                        n_out_valid = 1'b1;
                        n_pend2     = 1'b0;
                        n_state     = S_SEND;
                        n_sched     = 1'b0;
                        n_running   = 1'b0;
                        n_due       = '0;
                        n_begin     = '0;
                        n_active    = r_ent.back ? '0 : CW'(r_active + 1'b1);
                    end else begin
                        n_elapsed = w_elapsed;
                        n_state   = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_neg   = w_diff[LW];
                n_prod  = {32'b0, w_absdiff[LW-1:0]} * {{LW{1'b0}}, r_elapsed};
                n_state = S_DST;
            end
            S_DST: begin
                w_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_out.kind        = KIND_LEVEL;
                    n_out.entry_index = w_idx_ext[3:0];
                    n_out.level       = w_lv_ext[7:0];
                    n_out.last        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_pend2           = 1'b0;
                    n_state           = S_SEND;
                end
            end
            S_SEND: begin
                if (i_out_ready) begin
                    if (r_pend2) begin
                        n_out   = r_out2;
                        n_pend2 = 1'b0;
                    end else begin
                        n_out_valid = 1'b0;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_active    <= '0;
            r_sched     <= 1'b0;
            r_due       <= '0;
            r_running   <= 1'b0;
            r_begin     <= '0;
            r_out_valid <= 1'b0;
            r_pend2     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_active    <= n_active;
            r_sched     <= n_sched;
            r_due       <= n_due;
            r_running   <= n_running;
            r_begin     <= n_begin;
            r_out_valid <= n_out_valid;
            r_pend2     <= n_pend2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in      <= n_in;
        r_elapsed <= n_elapsed;
        r_prod    <= n_prod;
        r_neg     <= n_neg;
        r_out     <= n_out;
        r_out2    <= n_out2;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[AW-1:0]] <= w_wr_entry;
        end
        r_ent <= r_mem[r_active[AW-1:0]];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/core/lfks_chk.sv]
// Port-level checker for the LED fade keyframe sequencer, bound to the top level.
module lfks_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input lfks_pkg::t_in_word   i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input lfks_pkg::t_out_word  o_out_data
);

    import lfks_pkg::*;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result word is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after an accepted word");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last) |=> o_out_valid)
        else $error("second result word not presented at once");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result word changed");

    a_append_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.kind == KIND_ACK || o_out_data.kind == KIND_FULL))
            |-> o_out_data.last)
        else $error("append result not marked last");

endmodule

bind led_fade_keyframe_sequencer_unit lfks_chk u_lfks_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

[tb/led_fade_keyframe_sequencer_unit_tb.sv]
// Testbench for the LED fade keyframe sequencer: directed table, then random words.
module led_fade_keyframe_sequencer_unit_tb;
    import lfks_pkg::*;

    localparam int         TABLE_DEPTH = 16;
    localparam int         RANDOM_WORDS = 1930;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        t_in_word  w;
        bit        typed;
        int        n_typed;
        t_out_word r;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    logic [7:0]  ent_start [TABLE_DEPTH];
    logic [7:0]  ent_end [TABLE_DEPTH];
    logic [31:0] ent_fade [TABLE_DEPTH];
    logic [31:0] ent_delay [TABLE_DEPTH];
    logic        ent_rewind [TABLE_DEPTH];
    int unsigned ent_count = 0;
    int unsigned cur_entry = 0;
    bit          armed = 1'b0;
    bit          fading = 1'b0;
    logic [31:0] due_at = '0;
    logic [31:0] fade_t0 = '0;

    t_out_word   awaited_words [$];
    t_row        plan [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    bit          squeeze = 1'b0;
    logic [31:0] sim_ms = '0;

    led_fade_keyframe_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void rewind_sequence();
        cur_entry = 0;
        armed = 1'b0;
        fading = 1'b0;
        due_at = '0;
        fade_t0 = '0;
    endfunction

    function automatic void close_entry(input int unsigned e);
        rewind_sequence();
        if (!ent_rewind[e]) begin
            cur_entry = e + 1;
        end
    endfunction

    function automatic void expect_word(input t_out_word x);
        awaited_words = {awaited_words, x};
    endfunction

    function automatic int next_fade_words(input t_in_word w, output t_out_word r0,
                                           output t_out_word r1);
        t_out_word   res [2];
        int          n;
        int unsigned e;
        logic [31:0] lag;
        logic [31:0] elapsed;
        longint      d;
        longint      q;
        longint      lv;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        case (w.cmd)
            CMD_APPEND: begin
                if (ent_count < TABLE_DEPTH) begin
                    ent_start[ent_count] = w.start_level;
                    ent_end[ent_count] = w.end_level;
                    ent_fade[ent_count] = w.fade_ms;
                    ent_delay[ent_count] = w.delay_ms;
                    ent_rewind[ent_count] = w.go_back;
                    res[0] = '{kind: KIND_ACK, level: 8'd0, entry_index: ent_count[3:0],
                               last: 1'b0};
                    ent_count++;
                end else begin
                    res[0] = '{kind: KIND_FULL, level: 8'd0, entry_index: 4'd0, last: 1'b0};
                end
                n = 1;
            end
            CMD_CLEAR: begin
                rewind_sequence();
            end
            CMD_STEP: begin
                if (w.restart) begin
                    rewind_sequence();
                end
                if (cur_entry < ent_count) begin
                    e = cur_entry;
                    if (!armed) begin
                        due_at = w.now_ms + ent_delay[e];
                        armed = 1'b1;
                    end
                    lag = w.now_ms - due_at;
                    if (!lag[31]) begin
                        if (!fading) begin
                            fading = 1'b1;
                            fade_t0 = w.now_ms;
                            res[n] = '{kind: KIND_LEVEL, level: ent_start[e],
                                       entry_index: e[3:0], last: 1'b0};
                            n++;
                            if (ent_fade[e] == 32'd0) begin
                                res[n] = '{kind: KIND_LEVEL, level: ent_end[e],
                                           entry_index: e[3:0], last: 1'b0};
                                n++;
                                close_entry(e);
                            end
                        end else begin
                            elapsed = w.now_ms - fade_t0;
                            if (elapsed >= ent_fade[e]) begin
                                res[n] = '{kind: KIND_LEVEL, level: ent_end[e],
                                           entry_index: e[3:0], last: 1'b0};
                                n++;
                                close_entry(e);
                            end else begin
                                d = longint'(ent_end[e]) - longint'(ent_start[e]);
                                q = (d * longint'(elapsed)) / longint'(ent_fade[e]);
                                lv = longint'(ent_start[e]) + q;
                                res[n] = '{kind: KIND_LEVEL, level: lv[7:0],
                                           entry_index: e[3:0], last: 1'b0};
                                n++;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (n > 0) begin
            res[n - 1].last = 1'b1;
        end
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    function automatic void plan_row(input logic [1:0] c, input logic [31:0] t, input bit rs,
                                     input logic [7:0] s, input logic [7:0] f_end,
                                     input logic [31:0] f_len, input logic [31:0] f_dly,
                                     input bit gb, input bit typed, input int n_typed,
                                     input logic [1:0] k, input logic [3:0] ix);
        t_row row;
        row.w = '{cmd: c, now_ms: t, restart: rs, start_level: s, end_level: f_end,
                  fade_ms: f_len, delay_ms: f_dly, go_back: gb};
        row.typed = typed;
        row.n_typed = n_typed;
        row.r = '{kind: k, level: 8'd0, entry_index: ix, last: 1'b1};
        plan = {plan, row};
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int       sel;
        int       pick;
        bit       full;
        full = (ent_count >= TABLE_DEPTH);
        w.cmd = CMD_STEP;
        w.now_ms = $urandom;
        w.restart = $urandom_range(1);
        w.start_level = $urandom_range(255);
        w.end_level = $urandom_range(255);
        w.fade_ms = $urandom;
        w.delay_ms = $urandom;
        w.go_back = $urandom_range(1);
        sel = $urandom_range(999);
        if (sel >= 150 && sel < 153) begin
            w.cmd = CMD_CLEAR;
        end else if (sel >= 153 && sel < 163) begin
            w.cmd = CMD_SPARE;
        end else if (sel < 30 || (sel < 150 && !full)) begin
            w.cmd = CMD_APPEND;
            if (!full) begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    w.fade_ms = 32'd0;
                end else if (pick < 75) begin
                    w.fade_ms = $urandom_range(40, 1);
                end else if (pick < 95) begin
                    w.fade_ms = $urandom_range(500, 41);
                end
                pick = $urandom_range(99);
                if (pick < 30) begin
                    w.delay_ms = 32'd0;
                end else if (pick < 80) begin
                    w.delay_ms = $urandom_range(30, 1);
                end else if (pick < 90) begin
                    w.delay_ms = $urandom_range(500, 31);
                end else if (pick < 95) begin
                    w.delay_ms = 32'h7FFF_FFF8 + $urandom_range(16);
                end
                // rewind only from the final entry, so every entry stays reachable
                w.go_back = (ent_count == TABLE_DEPTH - 1);
            end
        end else begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                sim_ms = sim_ms + $urandom_range(6);
            end else if (pick < 90) begin
                sim_ms = sim_ms + $urandom_range(40, 7);
            end else if (pick < 97) begin
                sim_ms = sim_ms + $urandom_range(3000, 41);
            end else begin
                sim_ms = sim_ms + $urandom;
            end
            w.now_ms = sim_ms;
            w.restart = ($urandom_range(299) == 0);
        end
        return w;
    endfunction

    task automatic offer_word(input t_in_word w, input bit typed, input int n_typed,
                              input t_out_word typed_word);
        t_out_word p0;
        t_out_word p1;
        int        n;
        if (!calm && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        n = next_fade_words(w, p0, p1);
        if (typed) begin
            if (n_typed > 0) begin
                expect_word(typed_word);
            end
        end else begin
            if (n > 0) begin
                expect_word(p0);
            end
            if (n > 1) begin
                expect_word(p1);
            end
        end
    endtask

    initial begin : stimulus
        t_in_word w;
        int       sent;
        plan_row(CMD_STEP, 32'd0, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b1, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_SPARE, 32'hFFFF_FFFF, 1'b1, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 1'b1, 1'b1, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_APPEND, 32'd0, 1'b0, 8'd0, 8'd255, 32'd10, 32'd0, 1'b0,
                 1'b1, 1, KIND_ACK, 4'd0);
        plan_row(CMD_APPEND, 32'd0, 1'b0, 8'd255, 8'd0, 32'd0, 32'd5, 1'b0,
                 1'b1, 1, KIND_ACK, 4'd1);
        plan_row(CMD_STEP, 32'd100, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd103, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd110, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd111, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd116, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd120, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_APPEND, 32'd0, 1'b0, 8'd17, 8'd200, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0,
                 1'b1, 1, KIND_ACK, 4'd2);
        plan_row(CMD_STEP, 32'd200, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'h8000_00C8, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'h0000_00C8, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'h8000_00C7, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_APPEND, 32'd0, 1'b0, 8'd255, 8'd0, 32'd3, 32'd0, 1'b0,
                 1'b1, 1, KIND_ACK, 4'd3);
        plan_row(CMD_CLEAR, 32'd0, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b1, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd5, 1'b1, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd9, 1'b0, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_STEP, 32'd12, 1'b1, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b0, 0, KIND_LEVEL, 4'd0);
        plan_row(CMD_APPEND, 32'd0, 1'b1, 8'd128, 8'd127, 32'd1, 32'hFFFF_FFFF, 1'b0,
                 1'b1, 1, KIND_ACK, 4'd4);
        plan_row(CMD_SPARE, 32'd0, 1'b1, 8'd0, 8'd0, 32'd0, 32'd0, 1'b0,
                 1'b1, 0, KIND_LEVEL, 4'd0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (plan[k]) begin
            offer_word(plan[k].w, plan[k].typed, plan[k].n_typed, plan[k].r);
        end

        sim_ms = 32'd20;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            w = random_word();
            if (w.cmd != CMD_SPARE) begin
                sent++;
                if (sent == 300) begin
                    squeeze = 1'b1;
                end
                if (sent == 1200) begin
                    i_in_valid <= 1'b0;
                    do @(posedge i_clk); while (awaited_words.size() != 0);
                end
            end
            calm = (sent >= 700 && sent < 1000);
            offer_word(w, 1'b0, 0, '0);
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (awaited_words.size() != 0);
        repeat (24) @(posedge i_clk);
        if (mismatches == 0 && awaited_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : collect
        int        hold_left;
        t_out_word want;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready) begin
                if (awaited_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: kind %0d level %0d entry %0d last %0d",
                                 o_out_data.kind, o_out_data.level,
                                 o_out_data.entry_index, o_out_data.last);
                    end
                end else begin
                    want = awaited_words.pop_front();
                    if (o_out_data.kind !== want.kind || o_out_data.level !== want.level ||
                        o_out_data.entry_index !== want.entry_index ||
                        o_out_data.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"word mismatch: want kind %0d level %0d entry %0d ",
                                      "last %0d, got kind %0d level %0d entry %0d last %0d"},
                                     want.kind, want.level, want.entry_index, want.last,
                                     o_out_data.kind, o_out_data.level,
                                     o_out_data.entry_index, o_out_data.last);
                        end
                    end
                end
            end
            if (squeeze) begin
                squeeze = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 11);
            end
        end
    end

    initial begin : watchdog
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[led_fade_keyframe_sequencer_unit.f]
rtl/core/lfks_pkg.sv
rtl/core/lfks_div.sv
rtl/core/led_fade_keyframe_sequencer_unit.sv
rtl/core/lfks_chk.sv
tb/led_fade_keyframe_sequencer_unit_tb.sv
